FILE: rtl/alucc_pkg.sv
// Shared types and constants for the condition-code ALU.
// Holds the opcode list, the word structs of both channels and the flag bit positions.
// No dependencies.
package alucc_pkg;

  localparam int unsigned OpcodeW = 5;
  localparam int unsigned DataW   = 16;
  localparam int unsigned CcW     = 8;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_CMP    = 5'd4,
    OP_AND    = 5'd5,
    OP_BIT    = 5'd6,
    OP_OR     = 5'd7,
    OP_EOR    = 5'd8,
    OP_NEG    = 5'd9,
    OP_COM    = 5'd10,
    OP_INC    = 5'd11,
    OP_DEC    = 5'd12,
    OP_CLR    = 5'd13,
    OP_TST    = 5'd14,
    OP_ASR    = 5'd15,
    OP_LSL    = 5'd16,
    OP_LSR    = 5'd17,
    OP_ROL    = 5'd18,
    OP_ROR    = 5'd19,
    OP_DAA    = 5'd20,
    OP_MUL    = 5'd21,
    OP_SEX    = 5'd22,
    OP_ADD16  = 5'd23,
    OP_SUB16  = 5'd24,
    OP_CMP16  = 5'd25,
    OP_ANDCC  = 5'd26,
    OP_ORCC   = 5'd27,
    OP_BRANCH = 5'd28
  } alu_op_t;

  // Branch condition pairs, selected by cond[3:1]; cond[0] inverts.
  typedef enum logic [2:0] {
    BR_ALWAYS = 3'd0,
    BR_HI     = 3'd1,
    BR_CC     = 3'd2,
    BR_NE     = 3'd3,
    BR_VC     = 3'd4,
    BR_PL     = 3'd5,
    BR_GE     = 3'd6,
    BR_GT     = 3'd7
  } br_pair_t;

  // Condition-code bit positions: E F H I N Z V C
  localparam int unsigned CcC = 0;
  localparam int unsigned CcV = 1;
  localparam int unsigned CcZ = 2;
  localparam int unsigned CcN = 3;
  localparam int unsigned CcH = 5;

  localparam logic [7:0] ByteMax = 8'h7f;
  localparam logic [7:0] ByteMin = 8'h80;
  localparam logic [7:0] DaaLo   = 8'h06;
  localparam logic [7:0] DaaHi   = 8'h60;
  localparam logic [3:0] BcdMax  = 4'd9;
  localparam logic [3:0] BcdHiLm = 4'd8;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [DataW-1:0]   acc_value;
    logic [DataW-1:0]   operand_value;
    logic [CcW-1:0]     flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic [CcW-1:0]   flags_out;
    logic             branch_taken;
  } alu_out_t;

endpackage

FILE: rtl/cpu_alu_condition_codes.sv
// Eight-bit CPU ALU with condition codes: top level, two register stages.
// Depends on alucc_pkg for word types, opcodes and flag positions.
//
// Usage:
//   in_valid/in_ready carry one word: opcode, accumulator, operand and the
//   incoming condition-code byte. out_valid/out_ready return one word per
//   input word: result, updated condition codes and the branch-taken flag.
//   Every input word gives exactly one output word, in order.
//   A word taken into the input register makes one pass of ALU logic into
//   the result register and is presented on out_word from there.
//   Throughput: one word per cycle while the receiver keeps out_ready high,
//   set by the single ALU pass.
//   Reset (rst_n low, synchronous) empties both stages; no state is kept
//   between words. When the receiver holds out_ready low, the result
//   register holds its word, the input register fills behind it, and
//   in_ready drops once both are full; in_ready follows out_ready in the
//   same cycle, so nothing is lost or repeated.
module cpu_alu_condition_codes (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  alucc_pkg::alu_in_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output alucc_pkg::alu_out_t out_word
);
  import alucc_pkg::*;

  alu_in_t  s1_word_r;
  logic     s1_valid_r;
  alu_out_t out_word_r;
  logic     out_valid_r;
  alu_out_t alu_nxt;

  logic s1_adv;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= alu_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ALU pass
  logic [7:0]  x, m;
  logic        cin;
  logic [7:0]  f;
  logic [15:0] r;
  logic        br;
  logic [8:0]  add_t, sub_t, daa_t;
  logic [4:0]  half_t;
  logic        add_cin, sub_cin;
  logic [16:0] add16_t, sub16_t;
  logic [15:0] prod;
  logic [7:0]  daa_adj;
  logic [7:0]  logic_r;
  logic        br_raw;

  assign x   = s1_word_r.acc_value[7:0];
  assign m   = s1_word_r.operand_value[7:0];
  assign cin = s1_word_r.flags_in[CcC];

  always_comb begin
    case (alu_op_t'(s1_word_r.opcode))
      OP_ADC:  add_cin = cin;
      default: add_cin = 1'b0;
    endcase
    case (alu_op_t'(s1_word_r.opcode))
      OP_SBC:  sub_cin = cin;
      default: sub_cin = 1'b0;
    endcase
  end

  logic [7:0] sub_a, sub_b;
  assign sub_a = (alu_op_t'(s1_word_r.opcode) == OP_NEG) ? 8'd0 : x;
  assign sub_b = (alu_op_t'(s1_word_r.opcode) == OP_NEG) ? x : m;

  assign add_t   = {1'b0, x} + {1'b0, m} + {8'd0, add_cin};
  assign half_t  = {1'b0, x[3:0]} + {1'b0, m[3:0]} + {4'd0, add_cin};
  assign sub_t   = {1'b0, sub_a} - {1'b0, sub_b} - {8'd0, sub_cin};
  assign add16_t = {1'b0, s1_word_r.acc_value} + {1'b0, s1_word_r.operand_value};
  assign sub16_t = {1'b0, s1_word_r.acc_value} - {1'b0, s1_word_r.operand_value};
  assign prod    = {8'd0, x} * {8'd0, m};

  always_comb begin
    daa_adj = 8'd0;
    if (s1_word_r.flags_in[CcH] || (x[3:0] > BcdMax)) begin
      daa_adj = daa_adj | DaaLo;
    end
    if (cin || (x[7:4] > BcdMax) || ((x[7:4] > BcdHiLm) && (x[3:0] > BcdMax))) begin
      daa_adj = daa_adj | DaaHi;
    end
  end
  assign daa_t = {1'b0, x} + {1'b0, daa_adj};

  // Branch test on flags_in; cond[0] inverts the pair's sense
  logic fc, fv, fz, fn;
  assign fc = s1_word_r.flags_in[CcC];
  assign fv = s1_word_r.flags_in[CcV];
  assign fz = s1_word_r.flags_in[CcZ];
  assign fn = s1_word_r.flags_in[CcN];

  always_comb begin
    case (br_pair_t'(s1_word_r.operand_value[3:1]))
      BR_ALWAYS: br_raw = 1'b1;
      BR_HI:     br_raw = !(fc || fz);
      BR_CC:     br_raw = !fc;
      BR_NE:     br_raw = !fz;
      BR_VC:     br_raw = !fv;
      BR_PL:     br_raw = !fn;
      BR_GE:     br_raw = !(fn ^ fv);
      BR_GT:     br_raw = !(fz || (fn ^ fv));
      default:   br_raw = 1'b0;
    endcase
  end

  always_comb begin
    case (alu_op_t'(s1_word_r.opcode))
      OP_AND, OP_BIT: logic_r = x & m;
      OP_OR:          logic_r = x | m;
      default:        logic_r = x ^ m;
    endcase
  end

  always_comb begin
    f  = s1_word_r.flags_in;
    r  = 16'd0;
    br = 1'b0;
    case (alu_op_t'(s1_word_r.opcode))
      OP_ADD, OP_ADC: begin
        r      = {8'd0, add_t[7:0]};
        f[CcH] = half_t[4];
        f[CcV] = ~(x[7] ^ m[7]) & (x[7] ^ add_t[7]);
        f[CcC] = add_t[8];
        f[CcN] = add_t[7];
        f[CcZ] = (add_t[7:0] == 8'd0);
      end
      OP_SUB, OP_SBC, OP_CMP, OP_NEG: begin
        r      = (alu_op_t'(s1_word_r.opcode) == OP_CMP) ? {8'd0, x} : {8'd0, sub_t[7:0]};
        f[CcV] = (sub_a[7] ^ sub_b[7]) & (sub_a[7] ^ sub_t[7]);
        f[CcC] = sub_t[8];
        f[CcN] = sub_t[7];
        f[CcZ] = (sub_t[7:0] == 8'd0);
      end
      OP_AND, OP_OR, OP_EOR, OP_BIT: begin
        r      = (alu_op_t'(s1_word_r.opcode) == OP_BIT) ? {8'd0, x} : {8'd0, logic_r};
        f[CcN] = logic_r[7];
        f[CcZ] = (logic_r == 8'd0);
        f[CcV] = 1'b0;
      end
      OP_COM: begin
        r      = {8'd0, ~x};
        f[CcN] = ~x[7];
        f[CcZ] = (x == 8'hff);
        f[CcV] = 1'b0;
        f[CcC] = 1'b1;
      end
      OP_INC: begin
        r      = {8'd0, x + 8'd1};
        f[CcV] = (x == ByteMax);
        f[CcN] = r[7];
        f[CcZ] = (r[7:0] == 8'd0);
      end
      OP_DEC: begin
        r      = {8'd0, x - 8'd1};
        f[CcV] = (x == ByteMin);
        f[CcN] = r[7];
        f[CcZ] = (r[7:0] == 8'd0);
      end
      OP_CLR: begin
        f[CcN] = 1'b0;
        f[CcZ] = 1'b1;
        f[CcV] = 1'b0;
        f[CcC] = 1'b0;
      end
      OP_TST: begin
        r      = {8'd0, x};
        f[CcN] = x[7];
        f[CcZ] = (x == 8'd0);
        f[CcV] = 1'b0;
      end
      OP_ASR, OP_LSR, OP_ROR: begin
        case (alu_op_t'(s1_word_r.opcode))
          OP_ASR:  r = {8'd0, x[7], x[7:1]};
          OP_LSR:  r = {8'd0, 1'b0, x[7:1]};
          default: r = {8'd0, cin, x[7:1]};
        endcase
        f[CcC] = x[0];
        f[CcN] = r[7];
        f[CcZ] = (r[7:0] == 8'd0);
      end
      OP_LSL, OP_ROL: begin
        r      = (alu_op_t'(s1_word_r.opcode) == OP_ROL) ? {8'd0, x[6:0], cin}
                                                          : {8'd0, x[6:0], 1'b0};
        f[CcC] = x[7];
        f[CcV] = x[7] ^ x[6];
        f[CcN] = r[7];
        f[CcZ] = (r[7:0] == 8'd0);
      end
      OP_DAA: begin
        r = {8'd0, daa_t[7:0]};
        // carry is only ever set here, never cleared
        if (daa_t[8]) begin
          f[CcC] = 1'b1;
        end
        f[CcN] = daa_t[7];
        f[CcZ] = (daa_t[7:0] == 8'd0);
      end
      OP_MUL: begin
        r      = prod;
        f[CcC] = prod[7];
        f[CcZ] = (prod == 16'd0);
      end
      OP_SEX: begin
        r      = {{8{m[7]}}, m};
        f[CcN] = m[7];
        f[CcZ] = (m == 8'd0);
      end
      OP_ADD16: begin
        r      = add16_t[15:0];
        f[CcV] = ~(s1_word_r.acc_value[15] ^ s1_word_r.operand_value[15])
                 & (s1_word_r.acc_value[15] ^ add16_t[15]);
        f[CcC] = add16_t[16];
        f[CcN] = add16_t[15];
        f[CcZ] = (add16_t[15:0] == 16'd0);
      end
      OP_SUB16, OP_CMP16: begin
        r      = (alu_op_t'(s1_word_r.opcode) == OP_CMP16) ? s1_word_r.acc_value
                                                           : sub16_t[15:0];
        f[CcV] = (s1_word_r.acc_value[15] ^ s1_word_r.operand_value[15])
                 & (s1_word_r.acc_value[15] ^ sub16_t[15]);
        f[CcC] = sub16_t[16];
        f[CcN] = sub16_t[15];
        f[CcZ] = (sub16_t[15:0] == 16'd0);
      end
      OP_ANDCC: f = s1_word_r.flags_in & m;
      OP_ORCC:  f = s1_word_r.flags_in | m;
      OP_BRANCH: br = br_raw ^ s1_word_r.operand_value[0];
      default: begin
        r  = 16'd0;
        br = 1'b0;
      end
    endcase
    alu_nxt.result_value = r;
    alu_nxt.flags_out    = f;
    alu_nxt.branch_taken = br;
  end

  // Checks
  a_branch_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_word_r.opcode != OP_BRANCH)) |=> !out_word_r.branch_taken)
    else $error("branch flag raised for a non-branch opcode");

  a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_word_r.opcode <= OP_DAA)) |=> (out_word_r.result_value[15:8] == 8'd0))
    else $error("upper result byte set by an 8-bit operation");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("word left the input stage without reaching the result register");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("input stage lost a word while stalled");

endmodule

FILE: dv/tb_cpu_alu_condition_codes.sv
// Self-checking testbench for cpu_alu_condition_codes: opcode sweep, flag corner cases,
// back-to-back and back-pressure runs, then random words checked against a local predictor.
// Depends on alucc_pkg and the cpu_alu_condition_codes RTL.
module tb_cpu_alu_condition_codes;
  import alucc_pkg::*;

  localparam int StallLimit  = 500;
  localparam int DrainCycles = 4;
  localparam int PrintLimit  = 200;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  alu_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  alu_out_t out_word;

  alu_out_t expected_words[$];
  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  bit       idle_on        = 1'b1;
  int       hold_request   = 0;

  cpu_alu_condition_codes dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] set_nz8(logic [7:0] cc, logic [7:0] r);
    cc[CcN] = r[7];
    cc[CcZ] = (r == 8'h00);
    return cc;
  endfunction

  function automatic logic [7:0] set_nz16(logic [7:0] cc, logic [15:0] r);
    cc[CcN] = r[15];
    cc[CcZ] = (r == 16'h0000);
    return cc;
  endfunction

  // returns {flags, sum byte}
  function automatic logic [15:0] add_byte(logic [7:0] a, logic [7:0] b, logic ci,
                                           logic [7:0] cc);
    logic [8:0] sum;
    logic [4:0] half;
    sum  = {1'b0, a} + {1'b0, b} + {8'h00, ci};
    half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, ci};
    cc[CcH] = half[4];
    cc[CcV] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
    cc[CcC] = sum[8];
    return {set_nz8(cc, sum[7:0]), sum[7:0]};
  endfunction

  // returns {flags, difference byte}; H is left alone
  function automatic logic [15:0] sub_byte(logic [7:0] a, logic [7:0] b, logic ci,
                                           logic [7:0] cc);
    logic [8:0] diff;
    diff = {1'b0, a} - {1'b0, b} - {8'h00, ci};
    cc[CcV] = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
    cc[CcC] = diff[8];
    return {set_nz8(cc, diff[7:0]), diff[7:0]};
  endfunction

  // returns {flags, difference}
  function automatic logic [23:0] sub_word(logic [15:0] a, logic [15:0] b, logic [7:0] cc);
    logic [16:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    cc[CcV] = (a[15] ^ b[15]) & (a[15] ^ diff[15]);
    cc[CcC] = diff[16];
    return {set_nz16(cc, diff[15:0]), diff[15:0]};
  endfunction

  function automatic logic branch_holds(logic [3:0] cond, logic [7:0] cc);
    logic t;
    case (cond[3:1])
      BR_ALWAYS: t = 1'b1;
      BR_HI:     t = ~(cc[CcC] | cc[CcZ]);
      BR_CC:     t = ~cc[CcC];
      BR_NE:     t = ~cc[CcZ];
      BR_VC:     t = ~cc[CcV];
      BR_PL:     t = ~cc[CcN];
      BR_GE:     t = ~(cc[CcN] ^ cc[CcV]);
      default:   t = ~(cc[CcZ] | (cc[CcN] ^ cc[CcV]));
    endcase
    return cond[0] ? ~t : t;
  endfunction

  function automatic alu_out_t predict_alu(alu_in_t w);
    alu_out_t    o;
    logic [7:0]  x, m, cc, r8, adj;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic [15:0] r16;
    logic        cin, wide;
    x    = w.acc_value[7:0];
    m    = w.operand_value[7:0];
    cc   = w.flags_in;
    cin  = cc[CcC];
    r8   = 8'h00;
    r16  = 16'h0000;
    wide = 1'b0;
    o.branch_taken = 1'b0;
    case (w.opcode)
      OP_ADD: {cc, r8} = add_byte(x, m, 1'b0, cc);
      OP_ADC: {cc, r8} = add_byte(x, m, cin, cc);
      OP_SUB: {cc, r8} = sub_byte(x, m, 1'b0, cc);
      OP_SBC: {cc, r8} = sub_byte(x, m, cin, cc);
      OP_CMP: begin
        {cc, r8} = sub_byte(x, m, 1'b0, cc);
        r8 = x;
      end
      OP_AND: begin
        r8 = x & m;
        cc = set_nz8(cc, r8);
        cc[CcV] = 1'b0;
      end
      OP_BIT: begin
        cc = set_nz8(cc, x & m);
        cc[CcV] = 1'b0;
        r8 = x;
      end
      OP_OR: begin
        r8 = x | m;
        cc = set_nz8(cc, r8);
        cc[CcV] = 1'b0;
      end
      OP_EOR: begin
        r8 = x ^ m;
        cc = set_nz8(cc, r8);
        cc[CcV] = 1'b0;
      end
      OP_NEG: {cc, r8} = sub_byte(8'h00, x, 1'b0, cc);
      OP_COM: begin
        r8 = ~x;
        cc = set_nz8(cc, r8);
        cc[CcV] = 1'b0;
        cc[CcC] = 1'b1;
      end
      OP_INC: begin
        r8 = x + 8'h01;
        cc[CcV] = (x == ByteMax);
        cc = set_nz8(cc, r8);
      end
      OP_DEC: begin
        r8 = x - 8'h01;
        cc[CcV] = (x == ByteMin);
        cc = set_nz8(cc, r8);
      end
      OP_CLR: begin
        cc[CcN] = 1'b0;
        cc[CcZ] = 1'b1;
        cc[CcV] = 1'b0;
        cc[CcC] = 1'b0;
      end
      OP_TST: begin
        cc = set_nz8(cc, x);
        cc[CcV] = 1'b0;
        r8 = x;
      end
      OP_ASR: begin
        cc[CcC] = x[0];
        r8 = {x[7], x[7:1]};
        cc = set_nz8(cc, r8);
      end
      OP_LSL: begin
        cc[CcC] = x[7];
        cc[CcV] = x[7] ^ x[6];
        r8 = {x[6:0], 1'b0};
        cc = set_nz8(cc, r8);
      end
      OP_LSR: begin
        cc[CcC] = x[0];
        r8 = {1'b0, x[7:1]};
        cc = set_nz8(cc, r8);
      end
      OP_ROL: begin
        cc[CcC] = x[7];
        cc[CcV] = x[7] ^ x[6];
        r8 = {x[6:0], cin};
        cc = set_nz8(cc, r8);
      end
      OP_ROR: begin
        cc[CcC] = x[0];
        r8 = {cin, x[7:1]};
        cc = set_nz8(cc, r8);
      end
      OP_DAA: begin
        adj = 8'h00;
        if (cc[CcH] || x[3:0] > BcdMax) adj = adj | DaaLo;
        if (cin || x[7:4] > BcdMax || (x[7:4] > BcdHiLm && x[3:0] > BcdMax)) adj = adj | DaaHi;
        sum9 = {1'b0, x} + {1'b0, adj};
        // carry is only ever set here, never cleared
        if (sum9[8]) cc[CcC] = 1'b1;
        r8 = sum9[7:0];
        cc = set_nz8(cc, r8);
      end
      OP_MUL: begin
        wide = 1'b1;
        r16 = {8'h00, x} * {8'h00, m};
        cc[CcC] = r16[7];
        cc[CcZ] = (r16 == 16'h0000);
      end
      OP_SEX: begin
        wide = 1'b1;
        r16 = {{8{m[7]}}, m};
        cc = set_nz8(cc, m);
      end
      OP_ADD16: begin
        wide = 1'b1;
        sum17 = {1'b0, w.acc_value} + {1'b0, w.operand_value};
        r16 = sum17[15:0];
        cc[CcV] = ~(w.acc_value[15] ^ w.operand_value[15]) & (w.acc_value[15] ^ r16[15]);
        cc[CcC] = sum17[16];
        cc = set_nz16(cc, r16);
      end
      OP_SUB16: begin
        wide = 1'b1;
        {cc, r16} = sub_word(w.acc_value, w.operand_value, cc);
      end
      OP_CMP16: begin
        wide = 1'b1;
        {cc, r16} = sub_word(w.acc_value, w.operand_value, cc);
        r16 = w.acc_value;
      end
      OP_ANDCC:  cc = cc & m;
      OP_ORCC:   cc = cc | m;
      OP_BRANCH: o.branch_taken = branch_holds(w.operand_value[3:0], cc);
      default: ; // undefined opcodes: zero result, flags pass through
    endcase
    o.result_value = wide ? r16 : {8'h00, r8};
    o.flags_out    = cc;
    return o;
  endfunction

  // ---------------------------------------------------------------- driving and checking

  function automatic alu_in_t make_word(logic [4:0] op, logic [15:0] acc, logic [15:0] opd,
                                        logic [7:0] cc);
    alu_in_t w;
    w.opcode        = op;
    w.acc_value     = acc;
    w.operand_value = opd;
    w.flags_in      = cc;
    return w;
  endfunction

  // corner values turn up far more often than a flat draw would give them
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return {8'h00, ByteMax};
      3:       return {8'h00, ByteMin};
      4:       return 16'h8000;
      5:       return 16'h7fff;
      6:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(alu_in_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_words.push_back(predict_alu(w));
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < PrintLimit)
      $display("%0t: %s got %h want %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_word(alu_out_t got);
    alu_out_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word, result_value", got.result_value, 16'h0000);
      return;
    end
    want = expected_words.pop_front();
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", got.result_value, want.result_value);
    if (got.flags_out !== want.flags_out)
      report_mismatch("flags_out", {8'h00, got.flags_out}, {8'h00, want.flags_out});
    if (got.branch_taken !== want.branch_taken)
      report_mismatch("branch_taken", {15'h0, got.branch_taken}, {15'h0, want.branch_taken});
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
      check_word(out_word);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // every opcode, undefined ones too, against corner accumulator and operand values
  task automatic test_opcode_sweep();
    logic [15:0] corners [4];
    corners = '{16'h0000, 16'hffff, 16'h007f, 16'h0080};
    for (int op = 0; op < 32; op++)
      send_word(make_word(5'(op), corners[op % 4], corners[(op / 4) % 4],
                          (op % 2) ? 8'hff : 8'h00));
  endtask

  task automatic test_flag_corners();
    send_word(make_word(OP_INC, 16'h007f, 16'h0000, 8'h00));   // signed overflow
    send_word(make_word(OP_DEC, 16'h0080, 16'h0000, 8'h00));   // signed overflow
    send_word(make_word(OP_ADC, 16'h000f, 16'h0000, 8'h01));   // half carry from carry in
    send_word(make_word(OP_DAA, 16'h009a, 16'h0000, 8'h00));   // both nibbles adjusted
    send_word(make_word(OP_DAA, 16'h0015, 16'h0000, 8'h20));   // half carry forces low adjust
    send_word(make_word(OP_DAA, 16'h0012, 16'h0000, 8'h01));   // carry forces high adjust
    send_word(make_word(OP_MUL, 16'h00ff, 16'h00ff, 8'h00));
    send_word(make_word(OP_MUL, 16'hff00, 16'h1234, 8'hff));   // zero product
    send_word(make_word(OP_SEX, 16'h0000, 16'h0080, 8'h00));
    send_word(make_word(OP_SEX, 16'hffff, 16'hff7f, 8'hff));
    send_word(make_word(OP_CMP16, 16'h8000, 16'h0001, 8'h00));
    send_word(make_word(OP_ADD16, 16'hffff, 16'h0001, 8'h00));
    send_word(make_word(OP_SUB16, 16'h0000, 16'h0001, 8'h00));
  endtask

  task automatic test_random_mix(int count);
    alu_in_t w;
    for (int i = 0; i < count; i++) begin
      // lean on the branch test so all sixteen conditions see many flag bytes
      w.opcode        = ($urandom_range(0, 7) == 0) ? OP_BRANCH : 5'($urandom_range(0, 31));
      w.acc_value     = pick_value();
      w.operand_value = pick_value();
      w.flags_in      = 8'($urandom);
      send_word(w);
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    test_random_mix(count);
    idle_on = 1'b1;
  endtask

  // receiver holds off while words keep coming, so the pipe fills and in_ready drops
  task automatic test_receiver_hold(int count);
    hold_request = 40;
    test_random_mix(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_opcode_sweep();
    test_flag_corners();
    test_back_to_back(150);
    test_receiver_hold(60);
    test_random_mix(1000);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/alucc_pkg.sv
rtl/cpu_alu_condition_codes.sv
dv/tb_cpu_alu_condition_codes.sv
